@@ sv/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, quiet while reset is high
`define QUAT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication into the next cycle, checked through reset as well
`define QUAT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/quat_pkg.sv @@
// ----------------------------------------------------------------------------
// quat_pkg
// Types, codes and helper functions of the quota usage accounting table.
// ----------------------------------------------------------------------------
package quat_pkg;

   localparam int NUM_EXPORTS_DEF = 256;
   localparam int SIZE_BUCKETS    = 65;
   localparam int BKT_W           = 7;

   localparam logic [2:0] FN_SET    = 3'd0;
   localparam logic [2:0] FN_CREATE = 3'd1;
   localparam logic [2:0] FN_DELETE = 3'd2;
   localparam logic [2:0] FN_RESIZE = 3'd3;
   localparam logic [2:0] FN_THIN   = 3'd4;
   localparam logic [2:0] FN_CHECK  = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_NOEXP  = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_ENT, S_DISP, S_HRD, S_HGET, S_HMOD, S_HWB,
      S_CALC1, S_CALC2, S_EWB, S_RESP
   } state_type;

   typedef struct packed {
      logic [63:0]             hq;
      logic [63:0]             hqf;
      logic [63:0]             ft;
      logic [63:0]             ftf;
      logic [63:0]             bt;
      logic [63:0]             btt;
      logic [63:0]             btf;
      logic [1:0]              flags;
      logic [SIZE_BUCKETS-1:0] mask;
   } entry_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [BKT_W-1:0] bit_length(input logic [63:0] v);
      logic [BKT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = BKT_W'(i + 1);
      end
      return n;
   endfunction

endpackage

@@ sv/quota_usage_accounting_table_core.sv @@
// flow: failed lookups and unknown operations skip to the result; checks and set quota
// pass the dispatch state; a resize that moves a bucket also does a read-modify-write of
// two histogram buckets; one transaction in flight, the next request is accepted once
// the result is loaded, and the pace is set by the read-modify-write of the entry and
// histogram memories and by any stall on the result register
// reset: synchronous, clears entry valid bits, controller and result valid; no memory clear
// ----------------------------------------------------------------------------
// quota_usage_accounting_table_core
// Per-export usage counters, quotas and file size histogram held in memories.
// ----------------------------------------------------------------------------
module quota_usage_accounting_table_core #(
   parameter int NUM_EXPORTS = quat_pkg::NUM_EXPORTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_eid,
   input  logic [31:0] req_count,
   input  logic [63:0] req_new_blocks,
   input  logic [63:0] req_old_blocks,
   input  logic [31:0] req_hybrid_blocks,
   input  logic        req_fast_volume,
   input  logic        req_thin,
   input  logic        req_release_req,
   input  logic [63:0] req_quota,
   input  logic [63:0] req_quota_fast,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_clamped,
   output logic        rsp_quota_exceeded,
   output logic        rsp_quota_exceeded_fast,
   output logic        rsp_slow_ok,
   output logic        rsp_fast_ok
);

   localparam int EW    = (NUM_EXPORTS > 1) ? $clog2(NUM_EXPORTS) : 1;
   localparam int HDEP  = NUM_EXPORTS * quat_pkg::SIZE_BUCKETS;
   localparam int HAW   = (HDEP > 1) ? $clog2(HDEP) : 1;
   localparam int BW    = quat_pkg::BKT_W;

   quat_pkg::entry_type ent_mem [NUM_EXPORTS];
   logic [63:0]         hist_mem [HDEP];

   quat_pkg::state_type state_ff, state_in;
   logic [NUM_EXPORTS-1:0] valid_ff, valid_in;

   logic [2:0]  func_ff, func_in;
   logic [15:0] eid_ff, eid_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] nb_ff, nb_in, ob_ff, ob_in;
   logic [31:0] hyb_ff, hyb_in;
   logic        fast_ff, fast_in, thin_ff, thin_in, rel_ff, rel_in;
   logic [63:0] quota_ff, quota_in, quotaf_ff, quotaf_in;

   quat_pkg::entry_type ent_ff, ent_in, ent_rd_ff;
   logic [63:0] hist_rd_ff;
   logic [63:0] h_ff, h_in, n_ff, n_in, d_ff, d_in, nf_ff, nf_in;
   logic [BW-1:0] oi_ff, oi_in, ni_ff, ni_in, bkt_ff, bkt_in;
   logic        second_ff, second_in;
   logic [1:0]  status_ff, status_in;
   logic        clamped_ff, clamped_in, slow_ff, slow_in, fok_ff, fok_in;
   logic        report_ff, report_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_clamped_ff, rsp_clamped_in, rsp_qe_ff, rsp_qe_in;
   logic        rsp_qef_ff, rsp_qef_in, rsp_slow_ff, rsp_slow_in;
   logic        rsp_fok_ff, rsp_fok_in;

   logic          ent_rd, ent_we, hist_rd, hist_we;
   logic [EW-1:0] ent_addr, eidx;
   logic [HAW-1:0] hist_addr;
   logic           in_range;

   assign req_stall = (state_ff != quat_pkg::S_IDLE);
   assign eidx      = eid_ff[EW-1:0];
   assign in_range  = ({1'b0, eid_ff} < 17'(NUM_EXPORTS));
   assign hist_addr = HAW'(HAW'(eidx) * HAW'(quat_pkg::SIZE_BUCKETS) + HAW'(bkt_ff));

   // memories
   always_ff @(posedge clock) begin
      if (ent_rd) ent_rd_ff <= ent_mem[ent_addr];
      if (ent_we) ent_mem[eidx] <= ent_ff;
   end

   always_ff @(posedge clock) begin
      if (hist_rd) hist_rd_ff <= hist_mem[hist_addr];
      if (hist_we) hist_mem[hist_addr] <= h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= quat_pkg::S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;   eid_ff <= eid_in;     count_ff <= count_in;
      nb_ff <= nb_in;       ob_ff <= ob_in;       hyb_ff <= hyb_in;
      fast_ff <= fast_in;   thin_ff <= thin_in;   rel_ff <= rel_in;
      quota_ff <= quota_in; quotaf_ff <= quotaf_in;
      ent_ff <= ent_in;     h_ff <= h_in;         n_ff <= n_in;
      d_ff <= d_in;         nf_ff <= nf_in;       oi_ff <= oi_in;
      ni_ff <= ni_in;       bkt_ff <= bkt_in;     second_ff <= second_in;
      status_ff <= status_in; clamped_ff <= clamped_in;
      slow_ff <= slow_in;   fok_ff <= fok_in;     report_ff <= report_in;
      rsp_status_ff <= rsp_status_in; rsp_clamped_ff <= rsp_clamped_in;
      rsp_qe_ff <= rsp_qe_in; rsp_qef_ff <= rsp_qef_in;
      rsp_slow_ff <= rsp_slow_in; rsp_fok_ff <= rsp_fok_in;
   end

   always_comb begin
      logic [63:0] hyb64, nv, n2, n3, s;
      hyb64 = {32'd0, hyb_ff};
      nv = '0; n2 = '0; n3 = '0; s = '0;

      state_in = state_ff;     valid_in = valid_ff;
      func_in = func_ff;       eid_in = eid_ff;       count_in = count_ff;
      nb_in = nb_ff;           ob_in = ob_ff;         hyb_in = hyb_ff;
      fast_in = fast_ff;       thin_in = thin_ff;     rel_in = rel_ff;
      quota_in = quota_ff;     quotaf_in = quotaf_ff;
      ent_in = ent_ff;         h_in = h_ff;           n_in = n_ff;
      d_in = d_ff;             nf_in = nf_ff;         oi_in = oi_ff;
      ni_in = ni_ff;           bkt_in = bkt_ff;       second_in = second_ff;
      status_in = status_ff;   clamped_in = clamped_ff;
      slow_in = slow_ff;       fok_in = fok_ff;       report_in = report_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_clamped_in = rsp_clamped_ff;
      rsp_qe_in = rsp_qe_ff;   rsp_qef_in = rsp_qef_ff;
      rsp_slow_in = rsp_slow_ff; rsp_fok_in = rsp_fok_ff;
      ent_rd = 1'b0; ent_we = 1'b0; hist_rd = 1'b0; hist_we = 1'b0;
      ent_addr = req_eid[EW-1:0];

      case (state_ff)
         quat_pkg::S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;   eid_in = req_eid;   count_in = req_count;
               nb_in = req_new_blocks; ob_in = req_old_blocks;
               hyb_in = req_hybrid_blocks; fast_in = req_fast_volume;
               thin_in = req_thin;   rel_in = req_release_req;
               quota_in = req_quota; quotaf_in = req_quota_fast;
               ent_rd = 1'b1;
               state_in = quat_pkg::S_ENT;
            end
         end
         quat_pkg::S_ENT: begin
            ent_in = ent_rd_ff;
            oi_in = quat_pkg::bit_length(ob_ff);
            ni_in = quat_pkg::bit_length(nb_ff);
            status_in = quat_pkg::ST_OK;
            clamped_in = 1'b0; slow_in = 1'b0; fok_in = 1'b0;
            report_in = 1'b0;
            second_in = 1'b0;
            if (func_ff > quat_pkg::FN_CHECK) begin
               state_in = quat_pkg::S_RESP;
            end else if (!in_range || (!valid_ff[eidx] && func_ff != quat_pkg::FN_SET)) begin
               status_in = !in_range ? quat_pkg::ST_RANGE : quat_pkg::ST_NOEXP;
               if (func_ff == quat_pkg::FN_CHECK) begin
                  slow_in = 1'b1;
                  fok_in  = fast_ff;
               end
               state_in = quat_pkg::S_RESP;
            end else begin
               report_in = 1'b1;
               state_in = quat_pkg::S_DISP;
            end
         end
         quat_pkg::S_DISP: begin
            case (func_ff)
               quat_pkg::FN_SET: begin
                  if (!valid_ff[eidx]) begin
                     ent_in.ft = '0; ent_in.ftf = '0; ent_in.bt = '0;
                     ent_in.btt = '0; ent_in.btf = '0;
                     ent_in.flags = '0; ent_in.mask = '0;
                  end
                  ent_in.hq  = quota_ff;
                  ent_in.hqf = quotaf_ff;
                  valid_in[eidx] = 1'b1;
                  state_in = quat_pkg::S_EWB;
               end
               quat_pkg::FN_CREATE, quat_pkg::FN_DELETE: begin
                  bkt_in = '0;
                  state_in = quat_pkg::S_HRD;
               end
               quat_pkg::FN_RESIZE: begin
                  if (nb_ff < ob_ff) begin
                     nv = ob_ff - nb_ff;
                     if (ob_ff <= hyb64)     n2 = nv;
                     else if (nb_ff > hyb64) n2 = '0;
                     else                    n2 = hyb64 - nb_ff;
                  end else begin
                     nv = nb_ff - ob_ff;
                     if (ob_ff >= hyb64)      n2 = '0;
                     else if (nb_ff <= hyb64) n2 = nv;
                     else                     n2 = hyb64 - ob_ff;
                  end
                  d_in  = nv;
                  nf_in = fast_ff ? n2 : '0;
                  bkt_in = oi_ff;
                  if (nb_ff == ob_ff)      state_in = quat_pkg::S_RESP;
                  else if (oi_ff != ni_ff) state_in = quat_pkg::S_HRD;
                  else                     state_in = quat_pkg::S_CALC1;
               end
               quat_pkg::FN_THIN: begin
                  n_in = rel_ff ? {32'd0, count_ff}
                                : quat_pkg::sat_add(ent_ff.btt, {32'd0, count_ff});
                  state_in = (count_ff == '0) ? quat_pkg::S_RESP : quat_pkg::S_CALC1;
               end
               default: begin
                  if (!fast_ff)                fok_in = 1'b0;
                  else if (ent_ff.hqf == '0)   fok_in = 1'b1;
                  else fok_in = !((thin_ff ? ent_ff.btt : ent_ff.btf) >= ent_ff.hqf);
                  if (ent_ff.hq == '0) slow_in = 1'b1;
                  else slow_in = !((thin_ff ? ent_ff.btt : ent_ff.bt) >= ent_ff.hq);
                  state_in = quat_pkg::S_RESP;
               end
            endcase
         end
         quat_pkg::S_HRD: begin
            hist_rd = 1'b1;
            state_in = quat_pkg::S_HGET;
         end
         quat_pkg::S_HGET: begin
            h_in = ent_ff.mask[bkt_ff] ? hist_rd_ff : '0;
            state_in = quat_pkg::S_HMOD;
         end
         quat_pkg::S_HMOD: begin
            case (func_ff)
               quat_pkg::FN_CREATE: begin
                  h_in = quat_pkg::sat_add(h_ff, {32'd0, count_ff});
                  ent_in.ft = quat_pkg::sat_add(ent_ff.ft, {32'd0, count_ff});
                  if (fast_ff) ent_in.ftf = quat_pkg::sat_add(ent_ff.ftf, {32'd0, count_ff});
                  state_in = quat_pkg::S_HWB;
               end
               quat_pkg::FN_DELETE: begin
                  nv = {32'd0, count_ff};
                  if (nv > ent_ff.ft) begin
                     clamped_in = 1'b1;
                     nv = ent_ff.ft;
                  end
                  ent_in.ft = ent_ff.ft - nv;
                  n_in = nv;
                  state_in = quat_pkg::S_CALC1;
               end
               default: begin
                  if (!second_ff) h_in = (h_ff != '0) ? h_ff - 64'd1 : '0;
                  else            h_in = quat_pkg::sat_add(h_ff, 64'd1);
                  state_in = quat_pkg::S_HWB;
               end
            endcase
         end
         quat_pkg::S_HWB: begin
            hist_we = 1'b1;
            ent_in.mask[bkt_ff] = 1'b1;
            if (func_ff == quat_pkg::FN_RESIZE) begin
               if (!second_ff) begin
                  second_in = 1'b1;
                  bkt_in = ni_ff;
                  state_in = quat_pkg::S_HRD;
               end else begin
                  state_in = quat_pkg::S_CALC1;
               end
            end else begin
               state_in = quat_pkg::S_EWB;
            end
         end
         quat_pkg::S_CALC1: begin
            case (func_ff)
               quat_pkg::FN_DELETE: begin
                  n2 = (n_ff > h_ff) ? h_ff : n_ff;
                  h_in = h_ff - n2;
                  if (fast_ff) begin
                     n3 = n2;
                     if (n2 > ent_ff.ftf) begin
                        clamped_in = 1'b1;
                        n3 = ent_ff.ftf;
                     end
                     ent_in.ftf = ent_ff.ftf - n3;
                  end
                  state_in = quat_pkg::S_HWB;
               end
               quat_pkg::FN_RESIZE: begin
                  nv = nf_ff;
                  if (nb_ff < ob_ff) begin
                     if (nv > ent_ff.btf) begin
                        clamped_in = 1'b1;
                        nv = ent_ff.btf;
                     end
                     ent_in.btf = ent_ff.btf - nv;
                  end else if (fast_ff) begin
                     s = quat_pkg::sat_add(ent_ff.btf, nv);
                     if (!thin_ff) ent_in.flags[1] = (ent_ff.hqf != '0) && (s > ent_ff.hqf);
                     ent_in.btf = s;
                  end
                  d_in = (d_ff >= nv) ? d_ff - nv : '0;
                  state_in = quat_pkg::S_CALC2;
               end
               default: begin
                  if (rel_ff) begin
                     nv = n_ff;
                     if (nv > ent_ff.btt) begin
                        clamped_in = 1'b1;
                        nv = ent_ff.btt;
                     end
                     ent_in.btt = ent_ff.btt - nv;
                  end else if (ent_ff.hq != '0 && n_ff > ent_ff.hq) begin
                     ent_in.flags[0] = 1'b1;
                     status_in = quat_pkg::ST_REJECT;
                  end else begin
                     ent_in.flags[0] = 1'b0;
                     ent_in.btt = n_ff;
                  end
                  state_in = quat_pkg::S_EWB;
               end
            endcase
         end
         quat_pkg::S_CALC2: begin
            nv = d_ff;
            if (nb_ff < ob_ff) begin
               if (nv > ent_ff.bt) begin
                  clamped_in = 1'b1;
                  nv = ent_ff.bt;
               end
               ent_in.bt = ent_ff.bt - nv;
            end else begin
               s = quat_pkg::sat_add(ent_ff.bt, nv);
               if (!thin_ff) ent_in.flags[0] = (ent_ff.hq != '0) && (s > ent_ff.hq);
               ent_in.bt = s;
            end
            state_in = quat_pkg::S_EWB;
         end
         quat_pkg::S_EWB: begin
            ent_we = 1'b1;
            state_in = quat_pkg::S_RESP;
         end
         quat_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_clamped_in = clamped_ff;
               rsp_qe_in      = report_ff && ent_ff.flags[0];
               rsp_qef_in     = report_ff && ent_ff.flags[1];
               rsp_slow_in    = slow_ff;
               rsp_fok_in     = fok_ff;
               state_in = quat_pkg::S_IDLE;
            end
         end
         default: state_in = quat_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_clamped             = rsp_clamped_ff;
   assign rsp_quota_exceeded      = rsp_qe_ff;
   assign rsp_quota_exceeded_fast = rsp_qef_ff;
   assign rsp_slow_ok             = rsp_slow_ff;
   assign rsp_fast_ok             = rsp_fok_ff;

endmodule

@@ sv/quat_checker.sv @@
// ----------------------------------------------------------------------------
// quat_checker
// Port-level checks of the quota usage accounting table, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_clamped,
   input logic        rsp_quota_exceeded,
   input logic        rsp_quota_exceeded_fast
);

   // one transaction at a time: the input closes right after an accept
   `QUAT_ASSERT_SAME(a_one_in_flight, req_valid && !req_stall, ##1 req_stall)
   // result register is empty after reset
   `QUAT_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid)
   // a held result stays offered
   `QUAT_ASSERT_SAME(a_rsp_hold, rsp_valid && rsp_stall, ##1 rsp_valid)
   // failed lookups carry no flags and no clamp
   `QUAT_ASSERT_SAME(a_fail_quiet,
      rsp_valid && (rsp_status == quat_pkg::ST_RANGE || rsp_status == quat_pkg::ST_NOEXP),
      !rsp_clamped && !rsp_quota_exceeded && !rsp_quota_exceeded_fast)

endmodule

bind quota_usage_accounting_table_core quat_checker u_quat_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operations into the quota usage accounting table, keeps a shadow of
// every export entry and compares each response field by field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NEXP = quat_pkg::NUM_EXPORTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [15:0] req_eid = '0;
   logic [31:0] req_count = '0;
   logic [63:0] req_new_blocks = '0;
   logic [63:0] req_old_blocks = '0;
   logic [31:0] req_hybrid_blocks = '0;
   logic        req_fast_volume = 1'b0;
   logic        req_thin = 1'b0;
   logic        req_release_req = 1'b0;
   logic [63:0] req_quota = '0;
   logic [63:0] req_quota_fast = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_clamped;
   logic        rsp_quota_exceeded;
   logic        rsp_quota_exceeded_fast;
   logic        rsp_slow_ok;
   logic        rsp_fast_ok;

   quota_usage_accounting_table_core dut (.*);

   always #10 clock = ~clock;

   typedef struct packed {
      logic [1:0] status;
      logic       clamped;
      logic       qe;
      logic       qef;
      logic       slow_ok;
      logic       fast_ok;
   } outcome_type;

   // shadow table
   bit          sh_valid [NEXP];
   logic [63:0] sh_hq [NEXP], sh_hqf [NEXP], sh_ft [NEXP], sh_ftf [NEXP];
   logic [63:0] sh_bt [NEXP], sh_btt [NEXP], sh_btf [NEXP];
   logic [1:0]  sh_flags [NEXP];
   logic [63:0] sh_hist [NEXP][quat_pkg::SIZE_BUCKETS];

   outcome_type expected_outcomes[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  quiet_mode = 1'b0;      // no random idling on either side
   bit  hold_receiver = 1'b0;
   int  hold_cycles = 0;

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic int bits_of(logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   function automatic outcome_type account_op(
      logic [2:0] fn, logic [15:0] eid, logic [31:0] cnt, logic [63:0] nb,
      logic [63:0] ob, logic [31:0] hyb, logic fv, logic th, logic rel,
      logic [63:0] q, logic [63:0] qf);
      outcome_type o;
      int e, oi, ni;
      logic [63:0] n, d, nf, s, used, hy, cnt64;
      o = '0;
      hy = {32'd0, hyb};
      cnt64 = {32'd0, cnt};
      if (fn > quat_pkg::FN_CHECK) return o;
      if (eid >= NEXP) o.status = quat_pkg::ST_RANGE;
      else if (!sh_valid[eid] && fn != quat_pkg::FN_SET) o.status = quat_pkg::ST_NOEXP;
      if (o.status != quat_pkg::ST_OK) begin
         if (fn == quat_pkg::FN_CHECK) begin
            o.slow_ok = 1'b1;
            o.fast_ok = fv;
         end
         return o;
      end
      e = int'(eid);
      case (fn)
         quat_pkg::FN_SET: begin
            if (!sh_valid[e]) begin
               sh_valid[e] = 1'b1;
               sh_ft[e] = '0; sh_ftf[e] = '0; sh_bt[e] = '0;
               sh_btt[e] = '0; sh_btf[e] = '0; sh_flags[e] = '0;
               for (int b = 0; b < quat_pkg::SIZE_BUCKETS; b++) sh_hist[e][b] = '0;
            end
            sh_hq[e] = q;
            sh_hqf[e] = qf;
         end
         quat_pkg::FN_CREATE: begin
            sh_hist[e][0] = add_sat(sh_hist[e][0], cnt64);
            sh_ft[e] = add_sat(sh_ft[e], cnt64);
            if (fv) sh_ftf[e] = add_sat(sh_ftf[e], cnt64);
         end
         quat_pkg::FN_DELETE: begin
            n = cnt64;
            if (n > sh_ft[e]) begin
               o.clamped = 1'b1;
               n = sh_ft[e];
            end
            sh_ft[e] -= n;
            if (n > sh_hist[e][0]) n = sh_hist[e][0];
            sh_hist[e][0] -= n;
            if (fv) begin
               if (n > sh_ftf[e]) begin
                  o.clamped = 1'b1;
                  n = sh_ftf[e];
               end
               sh_ftf[e] -= n;
            end
         end
         quat_pkg::FN_RESIZE: begin
            if (nb != ob) begin
               if (nb < ob) begin
                  d = ob - nb;
                  if (ob <= hy) nf = d;
                  else if (nb > hy) nf = '0;
                  else nf = hy - nb;
               end else begin
                  d = nb - ob;
                  if (ob >= hy) nf = '0;
                  else if (nb <= hy) nf = d;
                  else nf = hy - ob;
               end
               oi = bits_of(ob);
               ni = bits_of(nb);
               if (oi != ni) begin
                  if (sh_hist[e][oi] > 0) sh_hist[e][oi] -= 64'd1;
                  sh_hist[e][ni] = add_sat(sh_hist[e][ni], 64'd1);
               end
               if (!fv) nf = '0;
               if (nb < ob) begin
                  if (nf > sh_btf[e]) begin
                     o.clamped = 1'b1;
                     nf = sh_btf[e];
                  end
                  sh_btf[e] -= nf;
                  d = (d >= nf) ? d - nf : '0;
                  if (d > sh_bt[e]) begin
                     o.clamped = 1'b1;
                     d = sh_bt[e];
                  end
                  sh_bt[e] -= d;
               end else begin
                  if (fv) begin
                     s = add_sat(sh_btf[e], nf);
                     if (!th) sh_flags[e][1] = (sh_hqf[e] > 0 && s > sh_hqf[e]);
                     sh_btf[e] = s;
                  end
                  d = (d >= nf) ? d - nf : '0;
                  s = add_sat(sh_bt[e], d);
                  if (!th) sh_flags[e][0] = (sh_hq[e] > 0 && s > sh_hq[e]);
                  sh_bt[e] = s;
               end
            end
         end
         quat_pkg::FN_THIN: begin
            if (cnt != 0) begin
               if (rel) begin
                  n = cnt64;
                  if (n > sh_btt[e]) begin
                     o.clamped = 1'b1;
                     n = sh_btt[e];
                  end
                  sh_btt[e] -= n;
               end else begin
                  s = add_sat(sh_btt[e], cnt64);
                  if (sh_hq[e] > 0 && s > sh_hq[e]) begin
                     sh_flags[e][0] = 1'b1;
                     o.status = quat_pkg::ST_REJECT;
                  end else begin
                     sh_flags[e][0] = 1'b0;
                     sh_btt[e] = s;
                  end
               end
            end
         end
         default: begin
            if (!fv) o.fast_ok = 1'b0;
            else if (sh_hqf[e] == 0) o.fast_ok = 1'b1;
            else begin
               used = th ? sh_btt[e] : sh_btf[e];
               o.fast_ok = used < sh_hqf[e];
            end
            if (sh_hq[e] == 0) o.slow_ok = 1'b1;
            else begin
               used = th ? sh_btt[e] : sh_bt[e];
               o.slow_ok = used < sh_hq[e];
            end
         end
      endcase
      o.qe = sh_flags[e][0];
      o.qef = sh_flags[e][1];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // one transaction on the request channel; valid stays up until the next call
   task automatic send_op(logic [2:0] fn, logic [15:0] eid, logic [31:0] cnt,
                          logic [63:0] nb, logic [63:0] ob, logic [31:0] hyb,
                          logic fv, logic th, logic rel, logic [63:0] q,
                          logic [63:0] qf);
      while (!quiet_mode && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn; req_eid <= eid; req_count <= cnt;
      req_new_blocks <= nb; req_old_blocks <= ob; req_hybrid_blocks <= hyb;
      req_fast_volume <= fv; req_thin <= th; req_release_req <= rel;
      req_quota <= q; req_quota_fast <= qf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_outcomes.push_back(account_op(fn, eid, cnt, nb, ob, hyb, fv, th, rel, q, qf));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // values near interesting edges, mostly small
   function automatic logic [63:0] pick_blocks();
      case ($urandom_range(7))
         0: return '1;
         1: return rnd64();
         2: return 64'd1 << $urandom_range(63);
         3: return '0;
         default: return 64'($urandom_range(300));
      endcase
   endfunction

   function automatic logic [15:0] pick_eid();
      case ($urandom_range(19))
         0: return 16'($urandom_range(65535, NEXP));
         1: return 16'hFFFF;
         default: return 16'($urandom_range(7));
      endcase
   endfunction

   task automatic random_op(bit sane);
      logic [2:0] fn;
      fn = sane ? 3'($urandom_range(5)) : 3'($urandom_range(7));
      send_op(fn, pick_eid(),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(20),
              pick_blocks(), pick_blocks(),
              $urandom_range(1) ? $urandom : $urandom_range(200),
              1'($urandom), 1'($urandom), 1'($urandom),
              $urandom_range(3) == 0 ? rnd64() : 64'($urandom_range(400)),
              $urandom_range(3) == 0 ? rnd64() : 64'($urandom_range(200)));
   endtask

   task automatic test_directed();
      send_op(quat_pkg::FN_CREATE, 16'd3, 32'd1, 0, 0, 0, 1, 0, 0, 0, 0);   // no such export
      send_op(quat_pkg::FN_CHECK, 16'hFFFF, 0, 0, 0, 0, 1, 0, 0, 0, 0);     // out of range
      send_op(quat_pkg::FN_CHECK, 16'(NEXP), 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_op(quat_pkg::FN_SET, 16'd0, 0, 0, 0, 0, 0, 0, 0, 64'd100, 64'd40);
      send_op(quat_pkg::FN_SET, 16'(NEXP - 1), 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_op(quat_pkg::FN_CREATE, 16'd0, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0, 0, 0);
      send_op(quat_pkg::FN_DELETE, 16'd0, 32'd5, 0, 0, 0, 1, 0, 0, 0, 0);
      send_op(quat_pkg::FN_DELETE, 16'd0, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0, 0, 0); // clamp
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, 64'd80, 64'd0, 32'd50, 1, 0, 0, 0, 0);
      // over quota
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, 64'd200, 64'd80, 32'd50, 1, 0, 0, 0, 0);
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, 64'd200, 64'd200, 32'd50, 1, 0, 0, 0, 0);
      // clamp
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, 64'd0, '1, 32'hFFFFFFFF, 1, 0, 0, 0, 0);
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, '1, 64'd0, 32'hFFFFFFFF, 1, 1, 0, 0, 0);
      // saturate
      send_op(quat_pkg::FN_RESIZE, 16'd0, 0, '1, 64'd5, 32'd0, 0, 0, 0, 0, 0);
      send_op(quat_pkg::FN_THIN, 16'd0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      send_op(quat_pkg::FN_THIN, 16'd0, 32'd60, 0, 0, 0, 0, 1, 0, 0, 0);
      send_op(quat_pkg::FN_THIN, 16'd0, 32'd60, 0, 0, 0, 0, 1, 0, 0, 0);     // rejected
      send_op(quat_pkg::FN_THIN, 16'd0, 32'hFFFFFFFF, 0, 0, 0, 0, 1, 1, 0, 0); // clamp
      send_op(quat_pkg::FN_CHECK, 16'd0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
      send_op(quat_pkg::FN_CHECK, 16'd0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      send_op(quat_pkg::FN_SET, 16'd0, 0, 0, 0, 0, 0, 0, 0, '1, '1);
      send_op(quat_pkg::FN_CHECK, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_op(3'd6, 16'd0, '1, '1, '1, '1, 1, 1, 1, '1, '1);
      send_op(3'd7, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (300) @(posedge clock);
            hold_receiver = 1'b0;
         end
         repeat (12) random_op(1'b1);
      join
      wait_drained();
      repeat (60) random_op(1'b1);
      wait_drained();                         // sender pause until drained
   endtask

   task automatic test_random();
      for (int b = 0; b < 8; b++) send_op(quat_pkg::FN_SET, 16'(b), 0, 0, 0, 0, 0, 0, 0,
                                          64'($urandom_range(500)),
                                          64'($urandom_range(200)));
      quiet_mode = 1'b1;
      repeat (150) random_op(1'b1);
      quiet_mode = 1'b0;
      repeat (600) random_op($urandom_range(9) != 0);
   endtask

   // receiver side stall
   always @(posedge clock) begin
      rsp_stall <= hold_receiver || (!quiet_mode && $urandom_range(99) < 12);
   end

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         idle_cycles <= 0;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected response", 8'd1, 8'd0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 8'(rsp_status), 8'(want.status));
            if (rsp_clamped !== want.clamped)
               report_mismatch("clamped", 8'(rsp_clamped), 8'(want.clamped));
            if (rsp_quota_exceeded !== want.qe)
               report_mismatch("quota_exceeded", 8'(rsp_quota_exceeded), 8'(want.qe));
            if (rsp_quota_exceeded_fast !== want.qef)
               report_mismatch("quota_exceeded_fast", 8'(rsp_quota_exceeded_fast),
                               8'(want.qef));
            if (rsp_slow_ok !== want.slow_ok)
               report_mismatch("slow_ok", 8'(rsp_slow_ok), 8'(want.slow_ok));
            if (rsp_fast_ok !== want.fast_ok)
               report_mismatch("fast_ok", 8'(rsp_fast_ok), 8'(want.fast_ok));
         end
      end else if (req_valid && !req_stall) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NEXP; i++) sh_valid[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+sv
sv/quat_pkg.sv
sv/quota_usage_accounting_table_core.sv
sv/quat_checker.sv
tb/testbench.sv
